>>> sv/appliance_event_reporter_unit_defines.svh
// Assertion macros shared by the appliance event reporter RTL.
// Depends on nothing; included by the top level.
`ifndef APPLIANCE_EVENT_REPORTER_UNIT_DEFINES_SVH
`define APPLIANCE_EVENT_REPORTER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define AERU_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define AERU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/aeru_pkg.sv
// Types and constants of the appliance event reporter.
// Depends on nothing; used by the front end, queue, back end, top level and testbench.
`default_nettype none

package aeru_pkg;

   typedef enum logic {
      ITEM_SAMPLE = 1'b0,
      ITEM_PIN    = 1'b1
   } item_kind_type;

   typedef struct packed {
      item_kind_type kind;
      logic [7:0]    sample;
   } item_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } queue_status_type;

   localparam logic CMD_PIN = 1'b1;

   localparam logic [2:0] REG_NODE_ID          = 3'd0;
   localparam logic [2:0] REG_WINDOW_LENGTH    = 3'd1;
   localparam logic [2:0] REG_LEVEL_THRESHOLD  = 3'd2;
   localparam logic [2:0] REG_ACTIVE_REDUCTION = 3'd3;
   localparam logic [2:0] REG_STEP_THRESHOLD   = 3'd4;
   localparam logic [2:0] REG_LEVEL_DEBOUNCE   = 3'd5;
   localparam logic [2:0] REG_STEP_DEBOUNCE    = 3'd6;

   localparam logic [4:0] NODE_ID_RESET          = 5'd0;
   localparam logic [6:0] WINDOW_LENGTH_RESET    = 7'd100;
   localparam logic [7:0] LEVEL_THRESHOLD_RESET  = 8'd12;
   localparam logic [7:0] ACTIVE_REDUCTION_RESET = 8'd2;
   localparam logic [7:0] STEP_THRESHOLD_RESET   = 8'd10;
   localparam logic [3:0] LEVEL_DEBOUNCE_RESET   = 4'd7;
   localparam logic [3:0] STEP_DEBOUNCE_RESET    = 4'd15;

   localparam logic [4:0] LEVEL_MID       = 5'd16;
   localparam logic [5:0] STEP_MID        = 6'd16;
   localparam logic [3:0] STEP_LOW_BASE   = 4'd15;
   localparam logic [5:0] STEP_HIGH_BASE  = 6'd17;
   localparam logic [7:0] MIN_RESET       = 8'hFF;
   localparam logic [7:0] COUNTDOWN_START = 8'd254;
   localparam logic [7:0] SLOT_STEP       = 8'h02;
   localparam logic [1:0] FIRST_BAND      = 2'b11;
   localparam logic [7:0] WRAP_SLOT       = 8'h08;
   localparam logic [7:0] WRAP_GROUP_INC  = 8'h02;

endpackage

`default_nettype wire

>>> sv/aeru_if.sv
// Handshake channel interfaces of the appliance event reporter.
// Depends on nothing; used by the front, back and top level.
`default_nettype none

interface aeru_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] sample;
   logic       pin_level;
   modport source (output valid, command, sample, pin_level, input ready);
   modport sink (input valid, command, sample, pin_level, output ready);
endinterface

interface aeru_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] report_first;
   logic [7:0] report_second;
   modport source (output valid, report_first, report_second, input ready);
   modport sink (input valid, report_first, report_second, output ready);
endinterface

interface aeru_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] index;
   logic [7:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> sv/aeru_front.sv
// Front end: accepts input transactions and classifies them into queue items.
// Depends on aeru_pkg and aeru_req_if.
`default_nettype none

module aeru_front (
   aeru_req_if.sink                  req_ch,
   input  aeru_pkg::queue_status_type q_status,
   output logic                      q_push,
   output aeru_pkg::item_type        q_item
);

   logic is_pin;

   assign is_pin       = (req_ch.command == aeru_pkg::CMD_PIN);
   assign req_ch.ready = !q_status.full;

   // A falling pin edge has no effect, so it is accepted and dropped here.
   assign q_push = req_ch.valid && req_ch.ready && (!is_pin || req_ch.pin_level);

   assign q_item.kind   = is_pin ? aeru_pkg::ITEM_PIN : aeru_pkg::ITEM_SAMPLE;
   assign q_item.sample = req_ch.sample;

endmodule

`default_nettype wire

>>> sv/aeru_queue.sv
// Short queue between the front end and the back end.
// Depends on aeru_pkg.
`default_nettype none

module aeru_queue #(
   parameter int DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  aeru_pkg::item_type         push_item,
   input  logic                       pop,
   output aeru_pkg::item_type         head_item,
   output aeru_pkg::queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   aeru_pkg::item_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign status.not_empty = (count_ff != '0);
   assign status.full      = (count_ff == FULL_CNT);
   assign head_item        = entry_ff[rd_ptr_ff];
   assign do_push          = push && !status.full;
   assign do_pop           = pop && status.not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

>>> sv/aeru_back.sv
// Back end: window statistics, activity and step scoring, report slots,
// configuration registers and the result register. Depends on aeru_pkg and aeru_if.
`default_nettype none

module aeru_back (
   input  logic                       clock,
   input  logic                       reset,
   input  aeru_pkg::item_type         q_item,
   input  aeru_pkg::queue_status_type q_status,
   output logic                       q_pop,
   aeru_csr_if.sink                   csr_ch,
   aeru_rsp_if.source                 rsp_ch
);

   // Configuration registers.
   logic [4:0] node_id_ff, node_id_in;
   logic [6:0] window_length_ff, window_length_in;
   logic [7:0] level_threshold_ff, level_threshold_in;
   logic [7:0] active_reduction_ff, active_reduction_in;
   logic [7:0] step_threshold_ff, step_threshold_in;
   logic [3:0] level_debounce_ff, level_debounce_in;
   logic [3:0] step_debounce_ff, step_debounce_in;

   // Measurement and report state.
   logic [6:0] window_count_ff, window_count_in;
   logic [7:0] window_max_ff, window_max_in;
   logic [7:0] window_min_ff, window_min_in;
   logic [7:0] random_accum_ff, random_accum_in;
   logic       is_active_ff, is_active_in;
   logic [4:0] level_score_ff, level_score_in;
   logic [5:0] step_score_ff, step_score_in;
   logic [7:0] reference_swing_ff, reference_swing_in;
   logic       step_flag_ff, step_flag_in;
   logic [1:0] slot_bits_ff, slot_bits_in;
   logic [7:0] msg_second_ff, msg_second_in;
   logic [7:0] slot_countdown_ff, slot_countdown_in;
   logic [7:0] next_slot_ff, next_slot_in;

   // Result register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_first_ff, rsp_first_in;
   logic [7:0] rsp_second_ff, rsp_second_in;

   logic              fire;
   logic              emit;
   logic [7:0]        emit_first;
   logic [7:0]        emit_second;
   logic [7:0]        max_upd;
   logic [7:0]        min_upd;
   logic [6:0]        count_upd;
   logic [6:0]        window_len;
   logic              window_close;
   logic [7:0]        swing;
   logic [7:0]        accum_upd;
   logic [7:0]        level_thr;
   logic              below;
   logic signed [6:0] level_raw;
   logic [4:0]        level_lo;
   logic [4:0]        level_hi;
   logic [4:0]        level_new;
   logic              step_up;
   logic              step_down;
   logic [5:0]        step_new;
   logic              go_off;
   logic              go_on;
   logic              step_low;
   logic              step_high;
   logic              dirty;
   logic              flag_new;
   logic              state_new;
   logic [7:0]        cd_dec;
   logic [1:0]        pin_band;
   logic [7:0]        pin_next;
   logic [7:0]        pin_second;

   assign fire  = q_status.not_empty && (!rsp_valid_ff || rsp_ch.ready);
   assign q_pop = fire;

   assign csr_ch.ready         = 1'b1;
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.report_first  = rsp_first_ff;
   assign rsp_ch.report_second = rsp_second_ff;

   // Window close datapath.
   assign max_upd      = (q_item.sample > window_max_ff) ? q_item.sample : window_max_ff;
   assign min_upd      = (q_item.sample < window_min_ff) ? q_item.sample : window_min_ff;
   assign count_upd    = window_count_ff + 7'd1;
   assign window_len   = (window_length_ff == '0) ? 7'd1 : window_length_ff;
   assign window_close = (count_upd >= window_len) || (count_upd == '0);
   assign swing        = (max_upd >= min_upd) ? (max_upd - min_upd) : 8'd0;
   assign accum_upd    = random_accum_ff + q_item.sample;

   assign level_thr = !is_active_ff ? level_threshold_ff :
                      (level_threshold_ff > active_reduction_ff) ?
                      (level_threshold_ff - active_reduction_ff) : 8'd0;
   assign below     = (swing < level_thr);
   assign level_raw = $signed({2'b00, level_score_ff}) + 7'sd1 - (below ? 7'sd2 : 7'sd0);
   assign level_lo  = aeru_pkg::LEVEL_MID - {1'b0, level_debounce_ff};
   assign level_hi  = aeru_pkg::LEVEL_MID + {1'b0, level_debounce_ff};

   always_comb begin
      if (level_raw < $signed({2'b00, level_lo})) begin
         level_new = level_lo;
      end else if (level_raw > $signed({2'b00, level_hi})) begin
         level_new = level_hi;
      end else begin
         level_new = level_raw[4:0];
      end
   end

   assign step_up   = (swing > reference_swing_ff) &&
                      ((swing - reference_swing_ff) > step_threshold_ff);
   assign step_down = (swing <= reference_swing_ff) &&
                      ((reference_swing_ff - swing) > step_threshold_ff);
   assign step_new  = step_up ? (step_score_ff + 6'd1) :
                      step_down ? (step_score_ff - 6'd1) : aeru_pkg::STEP_MID;

   assign go_off    = is_active_ff && (level_new <= level_lo);
   assign go_on     = !is_active_ff && (level_new >= level_hi);
   assign step_low  = step_new <= {2'b00, aeru_pkg::STEP_LOW_BASE - step_debounce_ff};
   assign step_high = step_new >= ({2'b00, step_debounce_ff} + aeru_pkg::STEP_HIGH_BASE);
   assign dirty     = go_off || go_on || step_low || step_high;
   assign flag_new  = !(go_off || go_on);
   assign state_new = go_on || (!go_off && !step_low && step_high);

   // Pin edge datapath.
   assign cd_dec     = slot_countdown_ff - aeru_pkg::SLOT_STEP;
   assign pin_band   = cd_dec[7:6] - 2'd1;
   assign pin_next   = {pin_band, random_accum_ff[3:1], 3'b000};
   assign pin_second = {msg_second_ff[7:4] + 4'd1, random_accum_ff[3:1], msg_second_ff[0]};

   always_comb begin
      node_id_in          = node_id_ff;
      window_length_in    = window_length_ff;
      level_threshold_in  = level_threshold_ff;
      active_reduction_in = active_reduction_ff;
      step_threshold_in   = step_threshold_ff;
      level_debounce_in   = level_debounce_ff;
      step_debounce_in    = step_debounce_ff;
      window_count_in     = window_count_ff;
      window_max_in       = window_max_ff;
      window_min_in       = window_min_ff;
      random_accum_in     = random_accum_ff;
      is_active_in        = is_active_ff;
      level_score_in      = level_score_ff;
      step_score_in       = step_score_ff;
      reference_swing_in  = reference_swing_ff;
      step_flag_in        = step_flag_ff;
      slot_bits_in        = slot_bits_ff;
      msg_second_in       = msg_second_ff;
      slot_countdown_in   = slot_countdown_ff;
      next_slot_in        = next_slot_ff;
      emit                = 1'b0;
      emit_first          = '0;
      emit_second         = '0;

      if (fire) begin
         case (q_item.kind)
            aeru_pkg::ITEM_SAMPLE: begin
               if (window_close) begin
                  window_count_in = '0;
                  window_max_in   = '0;
                  window_min_in   = aeru_pkg::MIN_RESET;
                  random_accum_in = accum_upd;
                  level_score_in  = level_new;
                  if (dirty) begin
                     if (go_on) begin
                        is_active_in = 1'b1;
                     end else if (go_off) begin
                        is_active_in = 1'b0;
                     end
                     reference_swing_in = swing;
                     step_score_in      = aeru_pkg::STEP_MID;
                     emit               = 1'b1;
                     emit_first         = {flag_new, node_id_ff, 2'b00};
                     emit_second        = {msg_second_ff[7:4], 3'b000, state_new};
                     msg_second_in      = {msg_second_ff[7:4] + 4'd1, accum_upd[3:1],
                                           state_new};
                     next_slot_in       = {aeru_pkg::FIRST_BAND, accum_upd[3:1], 3'b000};
                     step_flag_in       = flag_new;
                     slot_bits_in       = aeru_pkg::FIRST_BAND;
                     slot_countdown_in  = aeru_pkg::COUNTDOWN_START;
                  end else begin
                     step_score_in = step_new;
                  end
               end else begin
                  window_count_in = count_upd;
                  window_max_in   = max_upd;
                  window_min_in   = min_upd;
               end
            end
            aeru_pkg::ITEM_PIN: begin
               if (slot_countdown_ff != '0) begin
                  slot_countdown_in = cd_dec;
                  if (cd_dec == next_slot_ff) begin
                     emit         = 1'b1;
                     emit_first   = {step_flag_ff, node_id_ff, slot_bits_ff};
                     emit_second  = msg_second_ff;
                     slot_bits_in = pin_band;
                     if (pin_next == '0) begin
                        next_slot_in  = aeru_pkg::WRAP_SLOT;
                        msg_second_in = pin_second + aeru_pkg::WRAP_GROUP_INC;
                     end else begin
                        next_slot_in  = pin_next;
                        msg_second_in = pin_second;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end

      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            aeru_pkg::REG_NODE_ID:          node_id_in          = csr_ch.data[4:0];
            aeru_pkg::REG_WINDOW_LENGTH:    window_length_in    = csr_ch.data[6:0];
            aeru_pkg::REG_LEVEL_THRESHOLD:  level_threshold_in  = csr_ch.data;
            aeru_pkg::REG_ACTIVE_REDUCTION: active_reduction_in = csr_ch.data;
            aeru_pkg::REG_STEP_THRESHOLD:   step_threshold_in   = csr_ch.data;
            aeru_pkg::REG_LEVEL_DEBOUNCE:   level_debounce_in   = csr_ch.data[3:0];
            aeru_pkg::REG_STEP_DEBOUNCE:    step_debounce_in    = csr_ch.data[3:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_second_in = rsp_second_ff;
      if (fire && emit) begin
         rsp_valid_in  = 1'b1;
         rsp_first_in  = emit_first;
         rsp_second_in = emit_second;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_id_ff          <= aeru_pkg::NODE_ID_RESET;
         window_length_ff    <= aeru_pkg::WINDOW_LENGTH_RESET;
         level_threshold_ff  <= aeru_pkg::LEVEL_THRESHOLD_RESET;
         active_reduction_ff <= aeru_pkg::ACTIVE_REDUCTION_RESET;
         step_threshold_ff   <= aeru_pkg::STEP_THRESHOLD_RESET;
         level_debounce_ff   <= aeru_pkg::LEVEL_DEBOUNCE_RESET;
         step_debounce_ff    <= aeru_pkg::STEP_DEBOUNCE_RESET;
         window_count_ff     <= '0;
         window_max_ff       <= '0;
         window_min_ff       <= aeru_pkg::MIN_RESET;
         random_accum_ff     <= '0;
         is_active_ff        <= 1'b0;
         level_score_ff      <= aeru_pkg::LEVEL_MID;
         step_score_ff       <= aeru_pkg::STEP_MID;
         reference_swing_ff  <= '0;
         step_flag_ff        <= 1'b0;
         slot_bits_ff        <= '0;
         msg_second_ff       <= '0;
         slot_countdown_ff   <= '0;
         next_slot_ff        <= '0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         node_id_ff          <= node_id_in;
         window_length_ff    <= window_length_in;
         level_threshold_ff  <= level_threshold_in;
         active_reduction_ff <= active_reduction_in;
         step_threshold_ff   <= step_threshold_in;
         level_debounce_ff   <= level_debounce_in;
         step_debounce_ff    <= step_debounce_in;
         window_count_ff     <= window_count_in;
         window_max_ff       <= window_max_in;
         window_min_ff       <= window_min_in;
         random_accum_ff     <= random_accum_in;
         is_active_ff        <= is_active_in;
         level_score_ff      <= level_score_in;
         step_score_ff       <= step_score_in;
         reference_swing_ff  <= reference_swing_in;
         step_flag_ff        <= step_flag_in;
         slot_bits_ff        <= slot_bits_in;
         msg_second_ff       <= msg_second_in;
         slot_countdown_ff   <= slot_countdown_in;
         next_slot_ff        <= next_slot_in;
         rsp_valid_ff        <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
   end

endmodule

`default_nettype wire

>>> sv/appliance_event_reporter_unit.sv
// Appliance event reporter top level: front end, item queue and back end.
// A report passes the queue and result register once its transaction is accepted;
// one transaction per cycle is sustained unless the result stalls. Reset is
// synchronous and restores every register with a default at once, with no
// clearing pass. Depends on aeru_pkg, aeru_if, aeru_front, aeru_queue, aeru_back.
`default_nettype none
`include "appliance_event_reporter_unit_defines.svh"

module appliance_event_reporter_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   aeru_req_if.sink    req_ch,
   aeru_rsp_if.source  rsp_ch,
   aeru_csr_if.sink    csr_ch
);

   aeru_pkg::queue_status_type q_status;
   aeru_pkg::item_type         push_item;
   aeru_pkg::item_type         head_item;
   logic                       q_push;
   logic                       q_pop;

   aeru_front u_front (
      .req_ch   (req_ch),
      .q_status (q_status),
      .q_push   (q_push),
      .q_item   (push_item)
   );

   aeru_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .head_item (head_item),
      .status    (q_status)
   );

   aeru_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_item   (head_item),
      .q_status (q_status),
      .q_pop    (q_pop),
      .csr_ch   (csr_ch),
      .rsp_ch   (rsp_ch)
   );

   `AERU_ASSERT_SAME(a_pop_needs_item, clock, reset, q_pop, q_status.not_empty, "queue popped while empty")
   `AERU_ASSERT_SAME(a_no_pop_on_stall, clock, reset, rsp_ch.valid && !rsp_ch.ready, !q_pop, "back end ran while result stalled")
   `AERU_ASSERT_SAME(a_result_from_item, clock, reset, $rose(rsp_ch.valid), $past(q_pop), "result without a processed item")

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for appliance_event_reporter_unit: a scoreboard class
// predicts every report from the accepted transactions and register writes.
// Depends on aeru_pkg, aeru_if and the RTL of the appliance event reporter.
`default_nettype none

module testbench;
   import aeru_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 8;

   typedef struct packed {
      logic [7:0] first;
      logic [7:0] second;
   } report_pair_type;

   class report_scoreboard;
      logic [4:0]      node_id;
      logic [6:0]      win_len;
      logic [7:0]      lvl_thr;
      logic [7:0]      act_red;
      logic [7:0]      stp_thr;
      logic [3:0]      lvl_deb;
      logic [3:0]      stp_deb;
      logic [6:0]      win_cnt;
      logic [7:0]      win_hi;
      logic [7:0]      win_lo;
      logic [7:0]      seed_sum;
      logic            active;
      logic [4:0]      lvl_score;
      logic [5:0]      stp_score;
      logic [7:0]      ref_swing;
      logic [7:0]      hdr_byte;
      logic [7:0]      info_byte;
      logic [7:0]      countdown;
      logic [7:0]      slot_mark;
      report_pair_type expected_reports[$];
      int              errors;
      int              checked;
      int              items;

      function new();
         node_id   = NODE_ID_RESET;
         win_len   = WINDOW_LENGTH_RESET;
         lvl_thr   = LEVEL_THRESHOLD_RESET;
         act_red   = ACTIVE_REDUCTION_RESET;
         stp_thr   = STEP_THRESHOLD_RESET;
         lvl_deb   = LEVEL_DEBOUNCE_RESET;
         stp_deb   = STEP_DEBOUNCE_RESET;
         win_cnt   = '0;
         win_hi    = '0;
         win_lo    = MIN_RESET;
         seed_sum  = '0;
         active    = 1'b0;
         lvl_score = LEVEL_MID;
         stp_score = STEP_MID;
         ref_swing = '0;
         hdr_byte  = {1'b0, NODE_ID_RESET, 2'b00};
         info_byte = '0;
         countdown = '0;
         slot_mark = '0;
         errors    = 0;
         checked   = 0;
         items     = 0;
      endfunction

      function int pending();
         return expected_reports.size();
      endfunction

      function void write_reg(logic [2:0] idx, logic [7:0] data);
         case (idx)
            REG_NODE_ID: begin
               node_id  = data[4:0];
               hdr_byte = (hdr_byte & 8'h83) | {1'b0, data[4:0], 2'b00};
            end
            REG_WINDOW_LENGTH:    win_len = data[6:0];
            REG_LEVEL_THRESHOLD:  lvl_thr = data;
            REG_ACTIVE_REDUCTION: act_red = data;
            REG_STEP_THRESHOLD:   stp_thr = data;
            REG_LEVEL_DEBOUNCE:   lvl_deb = data[3:0];
            REG_STEP_DEBOUNCE:    stp_deb = data[3:0];
            default: ;
         endcase
      endfunction

      function void queue_report();
         report_pair_type r;
         r.first  = (hdr_byte & 8'h83) | {1'b0, node_id, 2'b00};
         r.second = info_byte;
         expected_reports.push_back(r);
      endfunction

      function void close_window(logic [7:0] last);
         logic [7:0] swing;
         logic [7:0] thr;
         logic [7:0] rise;
         logic [7:0] fall;
         logic [7:0] grp;
         int         lvl;
         int         lo;
         int         hi;
         bit         fire;
         fire = 1'b0;
         swing = (win_hi < win_lo) ? 8'd0 : win_hi - win_lo;
         seed_sum = seed_sum + last;
         thr = lvl_thr;
         if (active) thr = (thr > act_red) ? thr - act_red : 8'd0;
         lvl = int'(lvl_score) + 1;
         if (swing < thr) lvl = lvl - 2;
         lo = int'(LEVEL_MID) - int'(lvl_deb);
         hi = int'(LEVEL_MID) + int'(lvl_deb);
         if (lvl < lo) lvl = lo;
         if (lvl > hi) lvl = hi;
         lvl_score = lvl[4:0];
         rise = swing - ref_swing;
         fall = ref_swing - swing;
         if (swing > ref_swing && rise > stp_thr) stp_score = stp_score + 6'd1;
         else if (swing <= ref_swing && fall > stp_thr) stp_score = stp_score - 6'd1;
         else stp_score = STEP_MID;
         if (active && int'(lvl_score) <= lo) begin
            fire      = 1'b1;
            hdr_byte  = hdr_byte & 8'h7F;
            active    = 1'b0;
            info_byte = info_byte & 8'hFE;
         end else if (!active && int'(lvl_score) >= hi) begin
            fire      = 1'b1;
            hdr_byte  = hdr_byte & 8'h7F;
            active    = 1'b1;
            info_byte = info_byte | 8'h01;
         end else if (int'(stp_score) <= int'(STEP_LOW_BASE) - int'(stp_deb)) begin
            fire      = 1'b1;
            hdr_byte  = hdr_byte | 8'h80;
            info_byte = info_byte & 8'hFE;
         end else if (int'(stp_score) >= int'(STEP_HIGH_BASE) + int'(stp_deb)) begin
            fire      = 1'b1;
            hdr_byte  = hdr_byte | 8'h80;
            info_byte = info_byte | 8'h01;
         end
         if (fire) begin
            grp       = seed_sum & 8'h0E;
            ref_swing = swing;
            stp_score = STEP_MID;
            hdr_byte  = hdr_byte & 8'hFC;
            info_byte = info_byte & 8'hF1;
            queue_report();
            info_byte = info_byte + 8'h10;
            slot_mark = 8'hC0 | {grp[5:0], 2'b00};
            hdr_byte[1:0] = FIRST_BAND;
            info_byte = info_byte | grp;
            countdown = COUNTDOWN_START;
         end
      endfunction

      function void pin_high();
         logic [7:0] grp;
         if (countdown == 8'd0) return;
         countdown = countdown - SLOT_STEP;
         if (countdown != slot_mark) return;
         queue_report();
         info_byte = info_byte + 8'h10;
         grp       = seed_sum & 8'h0E;
         slot_mark = (countdown & 8'hC0) - 8'h40;
         slot_mark = slot_mark | {grp[5:0], 2'b00};
         hdr_byte  = {hdr_byte[7:2], slot_mark[7:6]};
         info_byte = (info_byte & 8'hF1) | grp;
         if (slot_mark == 8'd0) begin
            slot_mark = WRAP_SLOT;
            info_byte = info_byte + WRAP_GROUP_INC;
         end
      endfunction

      function void predict_item(logic command, logic [7:0] value, logic level);
         logic [6:0] len;
         items++;
         if (command == ITEM_PIN) begin
            if (level) pin_high();
            return;
         end
         if (value > win_hi) win_hi = value;
         if (value < win_lo) win_lo = value;
         win_cnt = win_cnt + 7'd1;
         len = (win_len != 7'd0) ? win_len : 7'd1;
         if (win_cnt < len && win_cnt != 7'd0) return;
         close_window(value);
         win_cnt = '0;
         win_hi  = '0;
         win_lo  = MIN_RESET;
      endfunction

      function void check_report(logic [7:0] first, logic [7:0] second);
         report_pair_type want;
         checked++;
         if (expected_reports.size() == 0) begin
            errors++;
            $display("%0t: unexpected report, expected none, actual %h %h",
                     $time, first, second);
            return;
         end
         want = expected_reports.pop_front();
         if (want.first !== first) begin
            errors++;
            $display("%0t: report_first mismatch, expected %h, actual %h",
                     $time, want.first, first);
         end
         if (want.second !== second) begin
            errors++;
            $display("%0t: report_second mismatch, expected %h, actual %h",
                     $time, want.second, second);
         end
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset;
   report_scoreboard sb;
   int               req_idle_pct;
   int               rsp_idle_pct;
   int               rsp_hold;
   int               quiet_cycles;
   logic [6:0]       cur_len;

   aeru_req_if req_ch ();
   aeru_rsp_if rsp_ch ();
   aeru_csr_if csr_ch ();

   appliance_event_reporter_unit u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_report(rsp_ch.report_first, rsp_ch.report_second);
         if (req_ch.valid && req_ch.ready)
            sb.predict_item(req_ch.command, req_ch.sample, req_ch.pin_level);
         if (csr_ch.valid && csr_ch.ready)
            sb.write_reg(csr_ch.index, csr_ch.data);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (rsp_hold != 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_hold <= rsp_hold - 1;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles, %0d reports outstanding",
                  $time, quiet_cycles, sb.pending());
         $display("testbench NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic drive_item(input item_kind_type kind, input logic [7:0] value,
                             input logic level);
      if (req_idle_pct != 0 && $urandom_range(0, 99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < req_idle_pct);
      end
      req_ch.valid     <= 1'b1;
      req_ch.command   <= kind;
      req_ch.sample    <= value;
      req_ch.pin_level <= level;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic wait_quiet();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
   endtask

   task automatic set_config(input logic [4:0] node, input logic [6:0] len,
                             input logic [7:0] lthr, input logic [7:0] ared,
                             input logic [7:0] sthr, input logic [3:0] ldeb,
                             input logic [3:0] sdeb);
      wait_quiet();
      write_reg(REG_NODE_ID, {3'b000, node});
      write_reg(REG_WINDOW_LENGTH, {1'b0, len});
      write_reg(REG_LEVEL_THRESHOLD, lthr);
      write_reg(REG_ACTIVE_REDUCTION, ared);
      write_reg(REG_STEP_THRESHOLD, sthr);
      write_reg(REG_LEVEL_DEBOUNCE, {4'b0000, ldeb});
      write_reg(REG_STEP_DEBOUNCE, {4'b0000, sdeb});
      csr_ch.valid <= 1'b0;
      cur_len = len;
   endtask

   task automatic run_random(input int goal);
      int         start;
      int         reps;
      int         amp;
      int         lo;
      int         n;
      int         k;
      logic [7:0] value;
      start = sb.items;
      while (sb.items - start < goal) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               case ($urandom_range(0, 3))
                  0: amp = 0;
                  1: amp = $urandom_range(0, 15);
                  2: amp = $urandom_range(0, 255);
                  default: amp = 255;
               endcase
               n = (cur_len == 7'd0) ? 1 : int'(cur_len);
               reps = (n > 8) ? 1 : $urandom_range(1, 16);
               repeat (reps) begin
                  lo = $urandom_range(0, 255 - amp);
                  for (k = 0; k < n; k++) begin
                     if (k == 0) value = 8'(lo);
                     else if (k == 1) value = 8'(lo + amp);
                     else value = 8'($urandom_range(lo, lo + amp));
                     drive_item(ITEM_SAMPLE, value, 1'($urandom_range(0, 1)));
                  end
               end
            end
            6, 7, 8: begin
               repeat ($urandom_range(1, 60))
                  drive_item(ITEM_PIN, 8'($urandom_range(0, 255)),
                             $urandom_range(0, 3) != 0);
            end
            default: begin
               drive_item(item_kind_type'($urandom_range(0, 1)),
                          8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
         endcase
      end
   endtask

   initial begin
      sb = new();
      reset            = 1'b1;
      req_idle_pct     = 0;
      rsp_idle_pct     = 0;
      rsp_hold         = 0;
      quiet_cycles     = 0;
      cur_len          = WINDOW_LENGTH_RESET;
      req_ch.valid     = 1'b0;
      req_ch.command   = ITEM_SAMPLE;
      req_ch.sample    = 8'h00;
      req_ch.pin_level = 1'b0;
      rsp_ch.ready     = 1'b0;
      csr_ch.valid     = 1'b0;
      csr_ch.index     = REG_NODE_ID;
      csr_ch.data      = 8'h00;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: idle pin edges, switch-on, falling and rising step events.
      set_config(5'd31, 7'd2, 8'd0, 8'd255, 8'd0, 4'd1, 4'd1);
      drive_item(ITEM_PIN, 8'h00, 1'b1);
      drive_item(ITEM_PIN, 8'hFF, 1'b0);
      drive_item(ITEM_SAMPLE, 8'h00, 1'b1);
      drive_item(ITEM_SAMPLE, 8'hFF, 1'b0);
      drive_item(ITEM_PIN, 8'hAA, 1'b1);
      drive_item(ITEM_PIN, 8'h55, 1'b0);
      drive_item(ITEM_SAMPLE, 8'd100, 1'b0);
      drive_item(ITEM_SAMPLE, 8'd100, 1'b1);
      drive_item(ITEM_SAMPLE, 8'd5, 1'b0);
      drive_item(ITEM_SAMPLE, 8'd5, 1'b0);
      drive_item(ITEM_SAMPLE, 8'd0, 1'b1);
      drive_item(ITEM_SAMPLE, 8'd10, 1'b1);
      drive_item(ITEM_SAMPLE, 8'd0, 1'b0);
      drive_item(ITEM_SAMPLE, 8'd20, 1'b0);
      repeat (6) drive_item(ITEM_PIN, 8'hFF, 1'b1);

      req_idle_pct = 23;
      rsp_idle_pct = 64;
      set_config(5'd3, 7'd2, 8'd40, 8'd30, 8'd20, 4'd1, 4'd1);
      run_random(250);
      set_config(5'd0, 7'd0, 8'd0, 8'd0, 8'd0, 4'd15, 4'd15);
      run_random(60);

      req_idle_pct = 64;
      rsp_idle_pct = 23;
      set_config(5'd10, 7'd4, 8'd255, 8'd255, 8'd0, 4'd15, 4'd15);
      run_random(250);
      set_config(5'd21, 7'd3, 8'd128, 8'd0, 8'd255, 4'd3, 4'd2);
      run_random(200);

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      set_config(5'd17, 7'd127, 8'd60, 8'd10, 8'd30, 4'd2, 4'd3);
      run_random(300);
      repeat (5) drive_item(ITEM_SAMPLE, 8'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)));

      // Shorter window than the samples already gathered: the next sample closes it.
      set_config(5'd31, 7'd2, 8'd100, 8'd50, 8'd60, 4'd1, 4'd1);
      rsp_hold <= 150;
      run_random(200);

      wait_quiet();
      $display("Checked %0d reports against %0d input transactions over seven settings,",
               sb.checked, sb.items);
      $display("window lengths 0 to 127, idle mixes and a 150-cycle output stall.");
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end
endmodule

`default_nettype wire

>>> sim.f
+incdir+sv
sv/aeru_pkg.sv
sv/aeru_if.sv
sv/aeru_front.sv
sv/aeru_queue.sv
sv/aeru_back.sv
sv/appliance_event_reporter_unit.sv
tb/testbench.sv
